// File: sv/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Payload types, round constants and state encoding for the stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [2047:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] init_h(input logic [2:0] i);
        return INIT_H[{~i, 5'b00000} +: 32];
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        return ROUND_K[{~i, 5'b00000} +: 32];
    endfunction

endpackage
`default_nettype wire

// File: sv/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte input, 64-byte block buffer memory, one round per cycle, digest out.
// Data bytes are taken one per cycle while idle; the 64th byte of a block holds the input
// through block load, the rounds and the final add before the next byte.
// End of message with c bytes in the block: padding and length fit in this block for c
// up to 55, above that an extra block is hashed; then eight digest transfers.
// Reset loads the initial hash values and clears counts; the memory is not cleared.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic [7:0]  mem_buf [64];
    logic [7:0]  r_rd_byte;
    logic        mem_we;
    logic [5:0]  mem_wa;
    logic [7:0]  mem_wd;
    logic [5:0]  mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_buf[mem_wa] <= mem_wd;
        end
        r_rd_byte <= mem_buf[mem_ra];
    end

    t_state      r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_s [8];
    logic [31:0] r_w [16];
    logic [63:0] r_bits, n_bits;
    logic [5:0]  r_cnt, n_cnt;
    logic [6:0]  r_step, n_step;
    logic        r_final, n_final;
    logic        r_eom, n_eom;
    logic        r_last, n_last;
    logic [2:0]  r_widx, n_widx;

    logic        acc;
    logic        do_add;
    logic        do_init;
    logic        shift_w;
    logic        do_round;
    logic        load_s;
    logic [31:0] w_new;
    logic [31:0] t1, t2;
    logic [31:0] e, a, x, y, s0, s1;

    assign acc = i_valid && o_ready;

    always_comb begin
        x     = r_w[1];
        y     = r_w[14];
        s0    = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
        s1    = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        e     = r_s[4];
        a     = r_s[0];
        t1    = r_s[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & r_s[5]) ^ (~e & r_s[6])) + round_k(r_step[5:0]) + r_w[0];
        t2    = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & r_s[1]) ^ (a & r_s[2]) ^ (r_s[1] & r_s[2]));
    end

    always_comb begin
        n_state  = r_state;
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_final  = r_final;
        n_eom    = r_eom;
        n_last   = r_last;
        n_widx   = r_widx;
        o_ready  = 1'b0;
        o_valid  = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = r_cnt;
        mem_wd   = i_data.data_byte;
        mem_ra   = 6'd0;
        shift_w  = 1'b0;
        do_round = 1'b0;
        load_s   = 1'b0;
        do_add   = 1'b0;
        do_init  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (acc) begin
                    if (i_data.has_byte) begin
                        mem_we = 1'b1;
                        n_bits = r_bits + 64'd8;
                        n_cnt  = r_cnt + 6'd1;
                    end
                    if (i_data.has_byte && r_cnt == 6'd63) begin
                        n_eom   = i_data.end_of_message;
                        n_final = 1'b0;
                        n_last  = 1'b0;
                        n_step  = 7'd0;
                        n_state = ST_LOAD;
                    end else if (i_data.end_of_message) begin
                        n_eom   = 1'b1;
                        n_final = 1'b0;
                        n_last  = 1'b0;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                mem_we  = 1'b1;
                mem_wd  = r_final ? 8'h00 : PAD_BYTE;
                n_final = 1'b1;
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_step  = 7'd0;
                    n_state = ST_LOAD;
                end else if (r_cnt == LEN_POS - 6'd1) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                mem_we = 1'b1;
                mem_wd = r_bits[{~r_cnt[2:0], 3'b000} +: 8];
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_last  = 1'b1;
                    n_step  = 7'd0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                mem_ra  = r_step[5:0];
                n_step  = r_step + 7'd1;
                load_s  = (r_step == 7'd0);
                shift_w = (r_step != 7'd0);
                if (r_step == 7'd64) begin
                    n_step  = 7'd0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                do_round = 1'b1;
                n_step   = r_step + 7'd1;
                if (r_step == 7'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                do_add = 1'b1;
                if (r_last) begin
                    n_widx  = 3'd0;
                    n_state = ST_EMIT;
                end else if (r_eom) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        do_init = 1'b1;
                        n_bits  = 64'd0;
                        n_cnt   = 6'd0;
                        n_eom   = 1'b0;
                        n_last  = 1'b0;
                        n_final = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bits  <= '0;
            r_cnt   <= '0;
            r_step  <= '0;
            r_final <= 1'b0;
            r_eom   <= 1'b0;
            r_last  <= 1'b0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_final <= n_final;
            r_eom   <= n_eom;
            r_last  <= n_last;
            r_widx  <= n_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else if (do_add) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_s[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s) begin
            for (int i = 0; i < 8; i++) r_s[i] <= r_h[i];
        end else if (do_round) begin
            r_s[7] <= r_s[6];
            r_s[6] <= r_s[5];
            r_s[5] <= r_s[4];
            r_s[4] <= r_s[3] + t1;
            r_s[3] <= r_s[2];
            r_s[2] <= r_s[1];
            r_s[1] <= r_s[0];
            r_s[0] <= t1 + t2;
        end
        if (shift_w) begin
            for (int i = 0; i < 15; i++) r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
            r_w[15] <= {r_w[15][23:0], r_rd_byte};
        end else if (do_round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_new;
        end
    end

    assign o_data.digest_word = r_h[r_widx];
    assign o_data.word_index  = r_widx;
    assign o_data.last_word   = (r_widx == 3'd7);

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE)
        else $error("ready outside idle");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output active together");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LEN |-> r_cnt >= LEN_POS)
        else $error("length bytes out of place");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("digest transfer changed while waiting");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_word |=> r_state == ST_IDLE)
        else $error("digest end did not return to idle");

endmodule
`default_nettype wire

// File: test/sha256_stream_hasher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte items with random gaps, computes digests independently and
// checks every digest word transfer in order against the computed words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_test;
    import sha256_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    sha256_stream_hasher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item digest_words[$];
    int        errors = 0;
    int        cycles = 0;
    bit        no_idle = 1'b0;
    bit        hold_send = 1'b0;
    logic      o_ready_seen = 1'b0;

    // model state
    logic [31:0] hv [8];
    logic [63:0] msg_bits;
    logic [7:0]  blk [64];
    int          blk_fill;

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        s = hv;
        for (int i = 0; i < 64; i++) begin
            t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + KTAB[i] + w[i];
            t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] = hv[i] + s[i];
    endtask

    task automatic restart_digest();
        hv = H_START;
        msg_bits = '0;
        blk_fill = 0;
    endtask

    task automatic predict_digest(input t_in_item it);
        logic [63:0] len;
        t_out_item r;
        if (it.has_byte) begin
            blk[blk_fill] = it.data_byte;
            msg_bits = msg_bits + 64'd8;
            blk_fill++;
            if (blk_fill == 64) begin
                compress();
                blk_fill = 0;
            end
        end
        if (it.end_of_message) begin
            len = msg_bits;
            blk[blk_fill] = PAD_BYTE;
            blk_fill++;
            if (blk_fill > 56) begin
                while (blk_fill < 64) begin
                    blk[blk_fill] = 8'h00;
                    blk_fill++;
                end
                compress();
                blk_fill = 0;
            end
            while (blk_fill < 56) begin
                blk[blk_fill] = 8'h00;
                blk_fill++;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                r.digest_word = hv[i];
                r.word_index = 3'(i);
                r.last_word = (i == 7);
                digest_words.push_back(r);
            end
            restart_digest();
        end
    endtask

    function automatic t_in_item mk(input logic [7:0] b, input logic hb, input logic eom);
        t_in_item it;
        it.data_byte = b;
        it.has_byte = hb;
        it.end_of_message = eom;
        return it;
    endfunction

    task automatic queue_message(input int len, input bit end_with_byte);
        for (int i = 0; i < len; i++) begin
            pending_items.push_back(mk(8'($urandom),
                1'b1, end_with_byte && (i == len - 1)));
        end
        if (!end_with_byte || len == 0) pending_items.push_back(mk(8'($urandom), 1'b0, 1'b1));
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_seen) begin
                if (pending_items.size() > 0 && !hold_send
                    && (no_idle || $urandom_range(99) >= 31)) begin
                    i_data <= pending_items.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= no_idle || ($urandom_range(99) >= 31);
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out_item exp_w;
        cycles <= cycles + 1;
        o_ready_seen <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) predict_digest(i_data);
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_words.size() == 0) begin
                $display("%0t: unexpected digest transfer %h", $time, o_data);
                errors++;
            end else begin
                exp_w = digest_words.pop_front();
                if (o_data.digest_word !== exp_w.digest_word)
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_w.digest_word, o_data.digest_word);
                if (o_data.word_index !== exp_w.word_index)
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_w.word_index, o_data.word_index);
                if (o_data.last_word !== exp_w.last_word)
                    $display("%0t: last_word expected %0d actual %0d", $time,
                             exp_w.last_word, o_data.last_word);
                if (o_data !== exp_w) errors++;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int n;
        restart_digest();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        // empty message, lone filler item, edge values, padding boundaries
        pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
        pending_items.push_back(mk(8'hff, 1'b0, 1'b0));
        pending_items.push_back(mk(8'h00, 1'b1, 1'b0));
        pending_items.push_back(mk(8'hff, 1'b1, 1'b1));
        pending_items.push_back(mk(8'ha5, 1'b1, 1'b1));
        pending_items.push_back(mk(8'h5a, 1'b1, 1'b0));
        pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
        queue_message(55, 1'b1);
        queue_message(56, 1'b0);
        queue_message(64, 1'b1);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        // let everything drain before random traffic
        hold_send = 1'b1;
        wait (digest_words.size() == 0 && !i_valid);
        repeat (200) @(posedge i_clk);
        hold_send = 1'b0;
        n = 0;
        while (n < 230) begin
            int len;
            if ($urandom_range(9) == 0) len = 0;
            else len = $urandom_range(1, 20);
            if ($urandom_range(19) == 0) len = $urandom_range(50, 70);
            if ($urandom_range(9) == 0)
                pending_items.push_back(mk(8'($urandom), 1'b0, 1'b0));
            queue_message(len, $urandom_range(1));
            n += len + 1;
            if (n > 60 && n < 160) no_idle = 1'b1;
            else no_idle = 1'b0;
            wait (pending_items.size() < 4);
        end
        no_idle = 1'b0;
        wait (pending_items.size() == 0 && !i_valid);
        wait (digest_words.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/sha256_pkg.sv
sv/sha256_stream_hasher.sv
test/sha256_stream_hasher_test.sv
